// File: hw/rtl/bps_pkg.sv
// Shared types and constants for the byte pattern search block.
// No dependencies; every other file imports this package.
package bps_pkg;

  localparam int BYTE_W     = 8;
  localparam int PAT_BYTES  = 32;   // storage behind the four pattern registers
  localparam int PAT_WORDS  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_REG_W  = 6;
  localparam int OFFSET_W   = 32;
  localparam int CALC_W     = 6;    // width for pattern index arithmetic

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_WORD_0 = 3'd0,
    REG_PAT_WORD_1 = 3'd1,
    REG_PAT_WORD_2 = 3'd2,
    REG_PAT_WORD_3 = 3'd3,
    REG_PAT_LENGTH = 3'd4
  } cfg_reg_e;

  typedef logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_t;
  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0]     pat_t;

  // item held in the input register, with the advance strobe
  typedef struct packed {
    logic              go;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } bps_step_t;

  // result produced by the matcher for the item in the input register
  typedef struct packed {
    logic                emit;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } bps_res_t;

endpackage

// File: hw/rtl/bps_ifs.sv
// Handshake channels of the byte pattern search block: data bytes in,
// results out, configuration writes. Depends on bps_pkg.
interface bps_stream_if import bps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface bps_result_if import bps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

interface bps_cfg_if import bps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bps_cfg_regs.sv
// Configuration registers: pattern words and pattern length, with the
// length clamped to 1..PATTERN_MAX. Depends on bps_pkg and bps_cfg_if.
module bps_cfg_regs import bps_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  bps_cfg_if.sink          cfg,
  output pat_t             pattern,
  output logic [LEN_W-1:0] eff_len
);

  pat_words_t           pat_words;
  logic [LEN_REG_W-1:0] pattern_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_words      <= '0;
      pattern_length <= LEN_REG_W'(1);
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_PAT_WORD_0: pat_words[0] <= cfg.data;
        REG_PAT_WORD_1: pat_words[1] <= cfg.data;
        REG_PAT_WORD_2: pat_words[2] <= cfg.data;
        REG_PAT_WORD_3: pat_words[3] <= cfg.data;
        REG_PAT_LENGTH: pattern_length <= cfg.data[LEN_REG_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign pattern = pat_t'(pat_words);

  always_comb begin
    if (pattern_length == '0)
      eff_len = LEN_W'(1);
    else if (pattern_length > LEN_REG_W'(PATTERN_MAX))
      eff_len = LEN_W'(PATTERN_MAX);
    else
      eff_len = LEN_W'(pattern_length);
  end

endmodule

// File: hw/rtl/bps_matcher.sv
// Search state (byte window, byte count, done flag) and the parallel
// window compare. Depends on bps_pkg.
module bps_matcher import bps_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  bps_step_t        step,
  input  pat_t             pattern,
  input  logic [LEN_W-1:0] eff_len,
  output bps_res_t         res
);

  logic [BYTE_W-1:0]   window [PATTERN_MAX-1];  // newest first
  logic [OFFSET_W-1:0] bytes_seen;
  logic                search_done;

  logic [BYTE_W-1:0]   cur      [PATTERN_MAX];
  logic [CALC_W-1:0]   pat_idx  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lane_hit;
  logic [OFFSET_W-1:0] len_m1;
  logic                match;

  assign len_m1 = OFFSET_W'(eff_len) - OFFSET_W'(1);

  // lane k compares the k-th newest byte with pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      cur[k]      = (k == 0) ? step.data_byte : window[(k == 0) ? 0 : k - 1];
      pat_idx[k]  = CALC_W'(eff_len) - CALC_W'(k) - CALC_W'(1);
      lane_hit[k] = (CALC_W'(k) >= CALC_W'(eff_len))
                    || (pattern[pat_idx[k][$clog2(PAT_BYTES)-1:0]] == cur[k]);
    end
  end

  assign match = !search_done && (bytes_seen >= len_m1) && (&lane_hit);

  always_comb begin
    res.emit         = step.go && !search_done && (match || step.last_byte);
    res.found        = match;
    res.match_offset = match ? (bytes_seen - len_m1) : '0;
  end

  // window is payload: entries are only read once bytes_seen covers them
  always_ff @(posedge clk) begin
    if (step.go && !search_done && !match && !step.last_byte) begin
      window[0] <= step.data_byte;
      for (int i = 1; i < PATTERN_MAX - 1; i++)
        window[i] <= window[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      search_done <= 1'b0;
    end else if (step.go) begin
      if (step.last_byte) begin
        bytes_seen  <= '0;
        search_done <= 1'b0;
      end else if (!search_done) begin
        if (match)
          search_done <= 1'b1;
        else if (bytes_seen != '1)
          bytes_seen <= bytes_seen + OFFSET_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/byte_pattern_search.sv
// Byte pattern search. Streams data bytes, one byte per handshake, and reports
// the zero-based offset of the first occurrence of the configured pattern
// (1..PATTERN_MAX bytes, set by pattern_length and the four pattern words).
// A found result is given for the matching byte, not at the last byte;
// later bytes of that search are swallowed up to the byte marked last. If
// the last byte arrives without a match, a not-found result (offset 0) is
// given. Either way the search restarts clean after the last byte. One byte
// per cycle is taken unless the result stalls. A byte passes the input
// register and the combinational window compare; its result is registered in the
// result register. The user writes configuration only while idle (not enforced).
module byte_pattern_search import bps_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input logic         clk,
  input logic         rst,
  bps_stream_if.sink  stream,
  bps_result_if.source result,
  bps_cfg_if.sink     cfg
);

  pat_t             pattern;
  logic [LEN_W-1:0] eff_len;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  // result register
  logic                res_valid;
  logic                res_found;
  logic [OFFSET_W-1:0] res_offset;

  logic      advance;
  bps_step_t step;
  bps_res_t  mres;

  bps_cfg_regs #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pattern (pattern),
    .eff_len (eff_len)
  );

  // item moves out of the input register when the result slot is free
  // or being emptied this cycle
  assign advance      = in_valid && (!res_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  assign step = '{go: advance, data_byte: in_byte, last_byte: in_last};

  bps_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pattern (pattern),
    .eff_len (eff_len),
    .res     (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      in_byte <= stream.data_byte;
      in_last <= stream.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mres.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mres.emit) begin
      res_found  <= mres.found;
      res_offset <= mres.match_offset;
    end
  end

  assign result.valid        = res_valid;
  assign result.found        = res_found;
  assign result.match_offset = res_offset;

endmodule

// File: hw/rtl/bps_checker.sv
// Port-level checks for byte_pattern_search, bound to the top level.
// Depends on bps_pkg and the top level's channel interfaces.
module bps_checker import bps_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic [OFFSET_W-1:0] out_offset,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_offset))
    else $error("result changed while stalled");

  // not-found results carry offset zero
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_offset == '0)
    else $error("not-found result with nonzero offset");

  // a fresh result follows an accepted byte via the input and result registers
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a recent input word");

  // configuration writes never stall
  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind byte_pattern_search bps_checker u_bps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (stream.valid),
  .in_ready   (stream.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_found  (result.found),
  .out_offset (result.match_offset),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready)
);
